FILE: rtl/cps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cps_pkg
// Types, codes and constants shared by the capacity-limited prefix scan.
// ----------------------------------------------------------------------------
package cps_pkg;

	localparam int MAX_SOURCES_DEF = 1024;
	localparam int DATA_W          = 64;
	localparam int IDX_W           = 11;
	localparam int CFG_IDX_W       = 2;

	// failure index value that means no failing source
	localparam logic [IDX_W-1:0] NO_SOURCE = 11'd1024;

	localparam logic [DATA_W-1:0] CAP_RESET = {DATA_W{1'b1}};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CAP_SUCC_BLOCKS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAP_PRUNE_RCPTS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAP_TERM_PAIRS    = 2'd2;

	typedef enum logic [1:0] {
		CHK_NONE      = 2'd0,
		CHK_OVERFLOW  = 2'd1,
		CHK_PARTITION = 2'd2
	} chk_t;

	typedef enum logic [2:0] {
		ST_COMPLETE      = 3'd0,
		ST_PARTIAL       = 3'd1,
		ST_FIRST_TOO_BIG = 3'd2,
		ST_BAD_PARTITION = 3'd3,
		ST_OVERFLOW      = 3'd4
	} status_t;

	typedef struct packed {
		logic [DATA_W-1:0] successor_blocks;
		logic [DATA_W-1:0] prune_receipts;
		logic [DATA_W-1:0] terminal_pairs;
		logic [DATA_W-1:0] successor_mass;
		logic [DATA_W-1:0] pruned_mass;
		logic [DATA_W-1:0] terminal_mass;
		logic [DATA_W-1:0] source_mass;
		logic              last_source;
	} src_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] run_successor_blocks;
		logic [DATA_W-1:0] run_prune_receipts;
		logic [DATA_W-1:0] run_terminal_pairs;
		logic [DATA_W-1:0] run_successor_mass;
		logic [DATA_W-1:0] run_pruned_mass;
		logic [DATA_W-1:0] run_terminal_mass;
		logic              plan_done;
		logic [2:0]        plan_status;
		logic [IDX_W-1:0]  committed_count;
		logic [IDX_W-1:0]  failure_index;
		logic [DATA_W-1:0] committed_mass;
	} res_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] successor_blocks;
		logic [DATA_W-1:0] prune_receipts;
		logic [DATA_W-1:0] terminal_pairs;
	} caps_t;

	// registered source plus its precomputed three-mass sum
	typedef struct packed {
		src_item_t         item;
		logic [DATA_W-1:0] out_mass;
		logic              out_mass_ovf;
	} prep_t;

endpackage
`default_nettype wire

FILE: rtl/cps_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cps_in_stage
// Input register: captures a source and the sum of its three output masses.
// ----------------------------------------------------------------------------
module cps_in_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire logic               move,
	input  wire cps_pkg::src_item_t src_item,
	output logic                    valid_s1,
	output cps_pkg::prep_t          prep_s1
);

	localparam int DW = cps_pkg::DATA_W;

	logic [DW:0] part;
	logic [DW:0] whole;

	assign part  = {1'b0, src_item.successor_mass} + {1'b0, src_item.pruned_mass};
	assign whole = {1'b0, part[DW-1:0]} + {1'b0, src_item.terminal_mass};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prep_s1.item         <= src_item;
			prep_s1.out_mass     <= whole[DW-1:0];
			prep_s1.out_mass_ovf <= part[DW] | whole[DW];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/cps_scan_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cps_scan_core
// Page state and per-source update: running totals, partition check,
// capacity-fitting prefix and the closing plan result.
// ----------------------------------------------------------------------------
module cps_scan_core #(
	parameter int MAX_SOURCES = cps_pkg::MAX_SOURCES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire cps_pkg::prep_t     prep,
	input  wire cps_pkg::caps_t     caps,
	output cps_pkg::res_item_t      result
);

	localparam int DW    = cps_pkg::DATA_W;
	localparam int IW    = cps_pkg::IDX_W;
	localparam int POS_W = $clog2(MAX_SOURCES + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SOURCES);

	logic [5:0][DW-1:0] tot_q, tot_d;
	logic [DW-1:0]      mass_sum_q, mass_sum_d;
	logic [DW-1:0]      decl_q, decl_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	cps_pkg::chk_t      chk_q, chk_d;
	logic [POS_W-1:0]   chk_pos_q, chk_pos_d;
	logic               ovf_seen_q, ovf_seen_d;
	logic [POS_W-1:0]   ovf_pos_q, ovf_pos_d;
	logic               broken_q, broken_d;
	logic [POS_W-1:0]   plen_q, plen_d;
	logic [DW-1:0]      pmass_q, pmass_d;
	logic               too_long_q, too_long_d;

	logic [5:0][DW-1:0] inc;
	logic [5:0][DW:0]   tsum;
	logic [5:0]         carry;
	logic [DW:0]        dsum;
	logic [DW-1:0]      mass_sum_inc;
	logic [POS_W-1:0]   pos_inc;
	logic               fits;

	assign inc[0] = prep.item.successor_blocks;
	assign inc[1] = prep.item.prune_receipts;
	assign inc[2] = prep.item.terminal_pairs;
	assign inc[3] = prep.item.successor_mass;
	assign inc[4] = prep.item.pruned_mass;
	assign inc[5] = prep.item.terminal_mass;

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			tsum[k]  = {1'b0, tot_q[k]} + {1'b0, inc[k]};
			carry[k] = tsum[k][DW];
		end
	end

	assign dsum         = {1'b0, decl_q} + {1'b0, prep.item.source_mass};
	assign mass_sum_inc = mass_sum_q + prep.out_mass;
	assign pos_inc      = pos_q + POS_W'(1);
	assign fits         = (tsum[0][DW-1:0] <= caps.successor_blocks) &&
	                      (tsum[1][DW-1:0] <= caps.prune_receipts) &&
	                      (tsum[2][DW-1:0] <= caps.terminal_pairs);

	always_comb begin
		tot_d      = tot_q;
		mass_sum_d = mass_sum_q;
		decl_d     = decl_q;
		pos_d      = pos_q;
		chk_d      = chk_q;
		chk_pos_d  = chk_pos_q;
		ovf_seen_d = ovf_seen_q;
		ovf_pos_d  = ovf_pos_q;
		broken_d   = broken_q;
		plen_d     = plen_q;
		pmass_d    = pmass_q;
		too_long_d = too_long_q;

		if (pos_q >= POS_MAX) begin
			too_long_d = 1'b1;
		end else begin
			if (chk_q == cps_pkg::CHK_NONE) begin
				if (prep.out_mass_ovf || dsum[DW]) begin
					chk_d     = cps_pkg::CHK_OVERFLOW;
					chk_pos_d = pos_q;
				end else if (prep.out_mass != prep.item.source_mass) begin
					chk_d     = cps_pkg::CHK_PARTITION;
					chk_pos_d = pos_q;
				end else begin
					decl_d = dsum[DW-1:0];
				end
			end
			if (!ovf_seen_q) begin
				if (|carry) begin
					ovf_seen_d = 1'b1;
					ovf_pos_d  = pos_q;
				end else begin
					for (int k = 0; k < 6; k++) begin
						tot_d[k] = tsum[k][DW-1:0];
					end
					mass_sum_d = mass_sum_inc;
					if (!broken_q) begin
						if (fits) begin
							plen_d  = pos_inc;
							pmass_d = mass_sum_inc;
						end else begin
							broken_d = 1'b1;
						end
					end
				end
			end
			pos_d = pos_inc;
		end
	end

	always_comb begin
		result.run_successor_blocks = tot_d[0];
		result.run_prune_receipts   = tot_d[1];
		result.run_terminal_pairs   = tot_d[2];
		result.run_successor_mass   = tot_d[3];
		result.run_pruned_mass      = tot_d[4];
		result.run_terminal_mass    = tot_d[5];
		result.plan_done            = prep.item.last_source;
		result.plan_status          = cps_pkg::ST_COMPLETE;
		result.committed_count      = '0;
		result.failure_index        = cps_pkg::NO_SOURCE;
		result.committed_mass       = '0;
		if (prep.item.last_source) begin
			priority if (too_long_d) begin
				result.plan_status   = cps_pkg::ST_OVERFLOW;
				result.failure_index = '0;
			end else if (chk_d == cps_pkg::CHK_OVERFLOW) begin
				result.plan_status   = cps_pkg::ST_OVERFLOW;
				result.failure_index = IW'(chk_pos_d);
			end else if (chk_d == cps_pkg::CHK_PARTITION) begin
				result.plan_status   = cps_pkg::ST_BAD_PARTITION;
				result.failure_index = IW'(chk_pos_d);
			end else if (ovf_seen_d) begin
				result.plan_status   = cps_pkg::ST_OVERFLOW;
				result.failure_index = IW'(ovf_pos_d);
			end else if (plen_d == '0) begin
				result.plan_status   = cps_pkg::ST_FIRST_TOO_BIG;
			end else begin
				result.plan_status     = (plen_d == pos_d) ? cps_pkg::ST_COMPLETE
				                                           : cps_pkg::ST_PARTIAL;
				result.committed_count = IW'(plen_d);
				result.committed_mass  = pmass_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q      <= '0;
			mass_sum_q <= '0;
			decl_q     <= '0;
			pos_q      <= '0;
			chk_q      <= cps_pkg::CHK_NONE;
			chk_pos_q  <= '0;
			ovf_seen_q <= 1'b0;
			ovf_pos_q  <= '0;
			broken_q   <= 1'b0;
			plen_q     <= '0;
			pmass_q    <= '0;
			too_long_q <= 1'b0;
		end else if (adv) begin
			if (prep.item.last_source) begin
				// close the page: start the next one from clean state
				tot_q      <= '0;
				mass_sum_q <= '0;
				decl_q     <= '0;
				pos_q      <= '0;
				chk_q      <= cps_pkg::CHK_NONE;
				chk_pos_q  <= '0;
				ovf_seen_q <= 1'b0;
				ovf_pos_q  <= '0;
				broken_q   <= 1'b0;
				plen_q     <= '0;
				pmass_q    <= '0;
				too_long_q <= 1'b0;
			end else begin
				tot_q      <= tot_d;
				mass_sum_q <= mass_sum_d;
				decl_q     <= decl_d;
				pos_q      <= pos_d;
				chk_q      <= chk_d;
				chk_pos_q  <= chk_pos_d;
				ovf_seen_q <= ovf_seen_d;
				ovf_pos_q  <= ovf_pos_d;
				broken_q   <= broken_d;
				plen_q     <= plen_d;
				pmass_q    <= pmass_d;
				too_long_q <= too_long_d;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/capacity_limited_prefix_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// capacity_limited_prefix_scan
// Streams one page of sources, emitting inclusive running totals per source
// and a plan result (status, committed prefix, failure index) on the last one.
// ----------------------------------------------------------------------------
// Path: a source passes the input register, then the page-state update into
//   the result register, before its result can transfer.
// Throughput: one source per cycle, back to back while results do not stall;
//   the page-state update (64-bit adds, capacity compares) is combinational.
// Reset: arst_n clears all page state and the handshake, and sets the three
//   capacity registers to all ones. No clearing pass is needed.
// ----------------------------------------------------------------------------
module capacity_limited_prefix_scan #(
	parameter int MAX_SOURCES = cps_pkg::MAX_SOURCES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration write port
	input  wire logic                            cfg_we,
	input  wire logic [cps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [cps_pkg::DATA_W-1:0]      cfg_data,
	// source channel
	input  wire logic                            src_valid,
	output logic                                 src_stall,
	input  wire cps_pkg::src_item_t              src_item,
	// result channel
	output logic                                 res_valid,
	input  wire logic                            res_stall,
	output cps_pkg::res_item_t                   res_item
);

	cps_pkg::caps_t     caps_q;
	cps_pkg::prep_t     prep_s1;
	cps_pkg::res_item_t result;
	logic               valid_s1;
	logic               move_s1;
	logic               src_take;

	// Capacity registers. Writes to an index past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			caps_q.successor_blocks <= cps_pkg::CAP_RESET;
			caps_q.prune_receipts   <= cps_pkg::CAP_RESET;
			caps_q.terminal_pairs   <= cps_pkg::CAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cps_pkg::REG_CAP_SUCC_BLOCKS: caps_q.successor_blocks <= cfg_data;
				cps_pkg::REG_CAP_PRUNE_RCPTS: caps_q.prune_receipts   <= cfg_data;
				cps_pkg::REG_CAP_TERM_PAIRS:  caps_q.terminal_pairs   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the staged source whenever the result register is empty or
	// its result transfers this cycle. The page state updates on that move,
	// so each source touches the state exactly once.
	assign move_s1   = valid_s1 && (!res_valid || !res_stall);
	// Hold off the source side only when the staged source cannot advance;
	// an empty input register still takes a source while a result waits.
	assign src_stall = valid_s1 && !move_s1;
	assign src_take  = src_valid && !src_stall;

	cps_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (src_take),
		.move     (move_s1),
		.src_item (src_item),
		.valid_s1 (valid_s1),
		.prep_s1  (prep_s1)
	);

	cps_scan_core #(
		.MAX_SOURCES (MAX_SOURCES)
	) u_scan_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (move_s1),
		.prep   (prep_s1),
		.caps   (caps_q),
		.result (result)
	);

	// Result register: load on a move, drop valid once the result transfers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (move_s1) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			res_item <= result;
		end
	end

endmodule
`default_nettype wire
